/* rtl/core/stereo_peak_meter_ballistics_macros.svh */
// ---------------------------------------------------------------------------
// stereo peak meter assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAK_METER_BALLISTICS_MACROS_SVH
`define STEREO_PEAK_METER_BALLISTICS_MACROS_SVH

// condition holds at every edge
`define SPM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define SPM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the next cycle
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/spm_pkg.sv */
// ---------------------------------------------------------------------------
// spm_pkg
// shared types, field widths and constants of the stereo peak meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spm_pkg;

	localparam int RING_DEPTH_DEF = 256;
	localparam int BAR_STEPS_DEF  = 190;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int RING_W   = 2 * MAG_W;
	localparam int LEVEL_W  = 16;
	localparam int GAIN_W   = 8;
	localparam int WIN_W    = 9;
	localparam int LIT_W    = 7;
	localparam int ZONE_W   = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam int GAIN_SHIFT = 8;
	localparam int BAR_SHIFT  = 15;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 16'h8000;
	localparam logic [GAIN_W-1:0]  ATTACK_RST  = 8'd51;
	localparam logic [GAIN_W-1:0]  RELEASE_RST = 8'd13;
	localparam logic [WIN_W-1:0]   WINDOW_RST  = 9'd200;
	localparam logic [LIT_W-1:0]   LIT_MAX     = 7'd127;

	// zone thresholds on position * 2 * ZONE_SCALE / bar steps
	localparam int ZONE_SCALE     = 90;
	localparam int ZONE_RED_ABOVE = 80;
	localparam int ZONE_YEL_ABOVE = 65;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_WINDOW  = 2'd2;

	typedef enum logic [ZONE_W-1:0] {
		ZONE_NONE,
		ZONE_GREEN,
		ZONE_YELLOW,
		ZONE_RED
	} zone_t;

	typedef struct packed {
		logic                       opcode;
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] left_level;
		logic [LEVEL_W-1:0] right_level;
		logic [LIT_W-1:0]   left_lit;
		logic [LIT_W-1:0]   right_lit;
		logic [ZONE_W-1:0]  left_zone;
		logic [ZONE_W-1:0]  right_zone;
	} meter_t;

	typedef struct packed {
		logic [GAIN_W-1:0] attack_gain;
		logic [GAIN_W-1:0] release_gain;
		logic [WIN_W-1:0]  window_len;
	} cfg_t;

	function automatic logic [MAG_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] s);
		logic [MAG_W-1:0] u;
		u = s;
		return s[SAMPLE_W-1] ? (~u + MAG_W'(1)) : u;
	endfunction

endpackage

/* rtl/core/spm_cfg.sv */
// ---------------------------------------------------------------------------
// spm_cfg
// register port holding the ballistics gains and the scan window
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spm_pkg::ADDR_W-1:0] paddr,
	input  logic [spm_pkg::DATA_W-1:0] pwdata,
	output logic [spm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output spm_pkg::cfg_t              cfg
);
	import spm_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_gain  <= ATTACK_RST;
			cfg_q.release_gain <= RELEASE_RST;
			cfg_q.window_len   <= WINDOW_RST;
		end else if (wr) begin
			unique case (reg_idx)
				REG_ATTACK:  cfg_q.attack_gain  <= pwdata[GAIN_W-1:0];
				REG_RELEASE: cfg_q.release_gain <= pwdata[GAIN_W-1:0];
				REG_WINDOW:  cfg_q.window_len   <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ATTACK:  prdata = DATA_W'(cfg_q.attack_gain);
			REG_RELEASE: prdata = DATA_W'(cfg_q.release_gain);
			REG_WINDOW:  prdata = DATA_W'(cfg_q.window_len);
			default:     prdata = '0;
		endcase
	end

endmodule

/* rtl/core/spm_ring.sv */
// ---------------------------------------------------------------------------
// spm_ring
// frame magnitude memory, one write port and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_ring #(
	parameter int DEPTH = spm_pkg::RING_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [spm_pkg::RING_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [spm_pkg::RING_W-1:0] rdata
);
	import spm_pkg::*;

	logic [RING_W-1:0] mem [DEPTH];
	logic [RING_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

/* rtl/core/spm_mul.sv */
// ---------------------------------------------------------------------------
// spm_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_mul #(
	parameter int A_W = spm_pkg::LEVEL_W,
	parameter int B_W = spm_pkg::GAIN_W
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod
);
	logic [A_W+B_W-1:0] prod_q;

	assign prod = prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

endmodule

/* rtl/core/stereo_peak_meter_ballistics.sv */
// ---------------------------------------------------------------------------
// stereo_peak_meter_ballistics
// stereo peak meter with attack/release smoothing and bar segment output
// ---------------------------------------------------------------------------
// item channel (item_valid, item_stall, item): a frame beat stores the
// magnitudes of one left/right sample pair and does not raise item_stall, so
// frames may arrive back to back.
// a tick beat scans the last n frames, n = min(window_len, frames stored,
// RING_DEPTH), one memory read per cycle, then runs the smoothing and bar
// math through one shared multiplier; item_stall is high from the cycle
// after the tick until the meter beat is loaded.
// meter channel (meter_valid, meter_stall, meter): one beat per tick, held in
// an output register; a stalled receiver holds the beat, and a later tick
// that finishes meanwhile waits in its last state with item_stall high.
// register port: attack_gain at 0x0, release_gain at 0x4, window_len at 0x8.
// reset: levels go to full scale, the ring counts as empty (no clearing
// pass), gains and window return to 51, 13 and 200.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_peak_meter_ballistics_macros.svh"

module stereo_peak_meter_ballistics #(
	parameter int RING_DEPTH = spm_pkg::RING_DEPTH_DEF,
	parameter int BAR_STEPS  = spm_pkg::BAR_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  spm_pkg::item_t             item,
	output logic                       meter_valid,
	input  logic                       meter_stall,
	output spm_pkg::meter_t            meter,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spm_pkg::ADDR_W-1:0] paddr,
	input  logic [spm_pkg::DATA_W-1:0] pwdata,
	output logic [spm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import spm_pkg::*;

	localparam int AW      = $clog2(RING_DEPTH);
	localparam int CW      = $clog2(RING_DEPTH + 1);
	localparam int NW      = (CW > WIN_W) ? CW : WIN_W;
	localparam int BSW     = $clog2(BAR_STEPS + 1);
	localparam int BW      = (BSW > GAIN_W) ? BSW : GAIN_W;
	localparam int PW      = LEVEL_W + BW;
	localparam int VW      = PW - BAR_SHIFT;
	localparam int HALF    = BAR_STEPS / 2;
	localparam int RED_MIN = ((ZONE_RED_ABOVE + 1) * BAR_STEPS + 2 * ZONE_SCALE - 1)
		/ (2 * ZONE_SCALE);
	localparam int YEL_MIN = ((ZONE_YEL_ABOVE + 1) * BAR_STEPS + 2 * ZONE_SCALE - 1)
		/ (2 * ZONE_SCALE);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL_LF,
		S_MUL_RF,
		S_MUL_LB,
		S_MUL_RB,
		S_LIT_R,
		S_OUT
	} state_t;

	state_t             state_q;
	cfg_t               cfg;
	logic [AW-1:0]      wp_q;
	logic [CW-1:0]      fill_q;
	logic [AW-1:0]      ra_q;
	logic [CW-1:0]      remain_q;
	logic               rd_vld_s1;
	logic [MAG_W-1:0]   pk_l_q;
	logic [MAG_W-1:0]   pk_r_q;
	logic [LEVEL_W-1:0] lvl_l_q;
	logic [LEVEL_W-1:0] lvl_r_q;
	logic [LIT_W-1:0]   lit_l_q;
	logic [ZONE_W-1:0]  zone_l_q;
	logic [LIT_W-1:0]   lit_r_q;
	logic [ZONE_W-1:0]  zone_r_q;
	meter_t             meter_q;
	logic               meter_valid_q;

	logic               item_fire;
	logic               ring_we;
	logic               ring_re;
	logic [RING_W-1:0]  ring_wdata;
	logic [RING_W-1:0]  ring_rdata;
	logic [AW-1:0]      wp_next;
	logic [AW-1:0]      ra_start;
	logic [AW-1:0]      ra_next;
	logic [NW-1:0]      n_a;
	logic [NW-1:0]      n_b;
	logic [CW-1:0]      scan_n;
	logic [MAG_W-1:0]   rd_l;
	logic [MAG_W-1:0]   rd_r;

	logic               up_l;
	logic               up_r;
	logic [LEVEL_W-1:0] diff_l;
	logic [LEVEL_W-1:0] diff_r;
	logic [LEVEL_W-1:0] mul_a;
	logic [BW-1:0]      mul_b;
	logic [PW-1:0]      mul_prod;
	logic [LEVEL_W-1:0] step;
	logic [LEVEL_W-1:0] new_l;
	logic [LEVEL_W-1:0] new_r;
	logic [VW-1:0]      bar_v;
	logic [VW-1:0]      bar_n;
	logic [VW-1:0]      bar_cl;
	logic [LIT_W-1:0]   lit_c;
	logic [ZONE_W-1:0]  zone_c;

	spm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spm_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ra_q),
		.rdata (ring_rdata)
	);

	spm_mul #(
		.A_W (LEVEL_W),
		.B_W (BW)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	assign item_stall  = (state_q != S_IDLE);
	assign item_fire   = item_valid && !item_stall;
	assign ring_we     = item_fire && (item.opcode == OP_FRAME);
	assign ring_wdata  = {mag16(item.right_sample), mag16(item.left_sample)};
	assign ring_re     = (state_q == S_SCAN) && (remain_q != '0);
	assign meter_valid = meter_valid_q;
	assign meter       = meter_q;

	assign wp_next  = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign ra_start = (wp_q == '0) ? AW'(RING_DEPTH - 1) : wp_q - AW'(1);
	assign ra_next  = (ra_q == '0) ? AW'(RING_DEPTH - 1) : ra_q - AW'(1);

	// frames to scan: window_len, bounded by the ring and by what has been written
	always_comb begin
		n_a    = (NW'(cfg.window_len) > NW'(RING_DEPTH)) ? NW'(RING_DEPTH)
			: NW'(cfg.window_len);
		n_b    = (n_a > NW'(fill_q)) ? NW'(fill_q) : n_a;
		scan_n = n_b[CW-1:0];
	end

	assign rd_l = ring_rdata[MAG_W-1:0];
	assign rd_r = ring_rdata[RING_W-1:MAG_W];

	// ballistics
	assign up_l   = pk_l_q > lvl_l_q;
	assign up_r   = pk_r_q > lvl_r_q;
	assign diff_l = up_l ? (pk_l_q - lvl_l_q) : (lvl_l_q - pk_l_q);
	assign diff_r = up_r ? (pk_r_q - lvl_r_q) : (lvl_r_q - pk_r_q);
	assign step   = mul_prod[GAIN_SHIFT +: LEVEL_W];
	assign new_l  = up_l ? (lvl_l_q + step) : (lvl_l_q - step);
	assign new_r  = up_r ? (lvl_r_q + step) : (lvl_r_q - step);

	always_comb begin
		case (state_q)
			S_MUL_LF: begin
				mul_a = diff_l;
				mul_b = up_l ? BW'(cfg.attack_gain) : BW'(cfg.release_gain);
			end
			S_MUL_RF: begin
				mul_a = diff_r;
				mul_b = up_r ? BW'(cfg.attack_gain) : BW'(cfg.release_gain);
			end
			S_MUL_LB: begin
				mul_a = lvl_l_q;
				mul_b = BW'(BAR_STEPS);
			end
			S_MUL_RB: begin
				mul_a = lvl_r_q;
				mul_b = BW'(BAR_STEPS);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// bar segments from the scaled level
	always_comb begin
		bar_v  = mul_prod[BAR_SHIFT +: VW];
		bar_n  = (bar_v == '0) ? '0 : ((bar_v - VW'(1)) >> 1);
		bar_cl = (bar_n > VW'(HALF)) ? VW'(HALF) : bar_n;
		lit_c  = (bar_cl > VW'(LIT_MAX)) ? LIT_MAX : bar_cl[LIT_W-1:0];
		if (bar_cl == '0) begin
			zone_c = ZONE_NONE;
		end else if (bar_cl >= VW'(RED_MIN)) begin
			zone_c = ZONE_RED;
		end else if (bar_cl >= VW'(YEL_MIN)) begin
			zone_c = ZONE_YELLOW;
		end else begin
			zone_c = ZONE_GREEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wp_q          <= '0;
			fill_q        <= '0;
			ra_q          <= '0;
			remain_q      <= '0;
			rd_vld_s1     <= 1'b0;
			pk_l_q        <= '0;
			pk_r_q        <= '0;
			lvl_l_q       <= LEVEL_FULL;
			lvl_r_q       <= LEVEL_FULL;
			lit_l_q       <= '0;
			zone_l_q      <= '0;
			lit_r_q       <= '0;
			zone_r_q      <= '0;
			meter_q       <= '0;
			meter_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ring_re;
			if (rd_vld_s1) begin
				if (rd_l > pk_l_q) begin
					pk_l_q <= rd_l;
				end
				if (rd_r > pk_r_q) begin
					pk_r_q <= rd_r;
				end
			end
			if (meter_valid_q && !meter_stall && (state_q != S_OUT)) begin
				meter_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (ring_we) begin
						wp_q <= wp_next;
						if (fill_q != CW'(RING_DEPTH)) begin
							fill_q <= fill_q + CW'(1);
						end
					end else if (item_fire) begin
						remain_q <= scan_n;
						ra_q     <= ra_start;
						pk_l_q   <= '0;
						pk_r_q   <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (remain_q != '0) begin
						remain_q <= remain_q - CW'(1);
						ra_q     <= ra_next;
					end else begin
						state_q <= S_MUL_LF;
					end
				end
				S_MUL_LF: begin
					state_q <= S_MUL_RF;
				end
				S_MUL_RF: begin
					lvl_l_q <= new_l;
					state_q <= S_MUL_LB;
				end
				S_MUL_LB: begin
					lvl_r_q <= new_r;
					state_q <= S_MUL_RB;
				end
				S_MUL_RB: begin
					lit_l_q  <= lit_c;
					zone_l_q <= zone_c;
					state_q  <= S_LIT_R;
				end
				S_LIT_R: begin
					lit_r_q  <= lit_c;
					zone_r_q <= zone_c;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!meter_valid_q || !meter_stall) begin
						meter_q.left_level  <= lvl_l_q;
						meter_q.right_level <= lvl_r_q;
						meter_q.left_lit    <= lit_l_q;
						meter_q.right_lit   <= lit_r_q;
						meter_q.left_zone   <= zone_l_q;
						meter_q.right_zone  <= zone_r_q;
						meter_valid_q       <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SPM_ASSERT_ALWAYS(a_level_range, (lvl_l_q <= LEVEL_FULL) && (lvl_r_q <= LEVEL_FULL), "smoothed level above full scale")
	`SPM_ASSERT_ALWAYS(a_fill_range, fill_q <= CW'(RING_DEPTH), "ring fill count beyond depth")
	`SPM_ASSERT_IMPL(a_zone_lit, meter_valid_q, ((meter_q.left_zone == ZONE_NONE) == (meter_q.left_lit == '0)) && ((meter_q.right_zone == ZONE_NONE) == (meter_q.right_lit == '0)), "zone and lit count disagree")
	`SPM_ASSERT_NEXT(a_tick_scan, item_fire && (item.opcode == OP_TICK), (state_q == S_SCAN) && item_stall, "tick beat did not start a scan")

endmodule
